/* rtl/hhap_pkg.sv */
package hhap_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_INDEX_W = 2;

   localparam logic [REG_INDEX_W-1:0] REG_ENABLED = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_TARGET_COURSE = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_BASE_SPEED = 2'd2;

   localparam logic [7:0] BASE_SPEED_RESET = 8'd127;

   typedef logic [1:0] command_type;
   typedef logic [8:0] angle_type;
   typedef logic [7:0] speed_type;
   typedef logic signed [8:0] drive_type;
   typedef logic signed [10:0] err_type;
   typedef logic [7:0] mag_type;

   localparam command_type CMD_TICK = 2'd0;
   localparam command_type CMD_MOVE = 2'd1;
   localparam command_type CMD_TURN = 2'd2;
   localparam command_type CMD_STOP = 2'd3;

   localparam int FULL_CIRCLE = 360;
   localparam int HALF_CIRCLE = 180;

   localparam err_type FULL_CIRCLE_ERR = err_type'(FULL_CIRCLE);
   localparam err_type HALF_CIRCLE_ERR = err_type'(HALF_CIRCLE);
   localparam err_type TURN_FULL_ERR = 11'sd25;
   localparam err_type TURN_HALF_ERR = 11'sd10;
   localparam err_type MOVE_DEADBAND_ERR = 11'sd1;

   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W = 17;
   localparam int RECIP_DEPTH = 256;
   localparam int PROD_W = RECIP_W + 8;

   typedef logic [RECIP_DEPTH-1:0][RECIP_W-1:0] recip_table_type;

   // Entry m holds ceil(m * 2^16 / 180), so that speed * entry >> 16 equals
   // speed * m / 180 rounded down for every 8-bit speed.
   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      for (int i = 0; i < RECIP_DEPTH; i++) begin
         t[i] = RECIP_W'((i * (1 << RECIP_SHIFT) + HALF_CIRCLE - 1) / HALF_CIRCLE);
      end
      return t;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

   typedef struct packed {
      logic enabled;
      angle_type target_course;
      speed_type base_speed;
   } cfg_type;

   typedef struct packed {
      logic moving;
      logic turning;
   } mode_type;

   typedef struct packed {
      logic valid;
      drive_type left_drive;
      drive_type right_drive;
   } result_type;

endpackage

/* rtl/hhap_csr.sv */
module hhap_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [hhap_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hhap_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hhap_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready,
   output hhap_pkg::cfg_type cfg
);
   import hhap_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic write_en;
   logic [REG_INDEX_W-1:0] reg_index;

   assign pready = 1'b1;
   assign write_en = psel & penable & pwrite & pready;
   assign reg_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_ENABLED: cfg_in.enabled = pwdata[0];
            REG_TARGET_COURSE: cfg_in.target_course = pwdata[8:0];
            REG_BASE_SPEED: cfg_in.base_speed = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ENABLED: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.enabled};
         REG_TARGET_COURSE: prdata = {{(CSR_DATA_W-9){1'b0}}, cfg_ff.target_course};
         REG_BASE_SPEED: prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.base_speed};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled <= 1'b0;
         cfg_ff.target_course <= '0;
         cfg_ff.base_speed <= BASE_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/hhap_law.sv */
module hhap_law (
   input  hhap_pkg::command_type command,
   input  hhap_pkg::angle_type heading,
   input  hhap_pkg::cfg_type cfg,
   input  hhap_pkg::mode_type mode,
   output hhap_pkg::result_type result,
   output hhap_pkg::mode_type mode_next
);
   import hhap_pkg::*;

   err_type raw_err;
   err_type wrap_err;
   err_type err;
   err_type abs_err;
   mag_type mag;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0] prod;
   speed_type quot;
   logic signed [9:0] slow_wide;
   drive_type slow;
   drive_type full_pos;
   drive_type full_neg;
   drive_type half_pos;
   drive_type half_neg;

   assign raw_err = $signed({2'b00, heading}) - $signed({2'b00, cfg.target_course});
   assign wrap_err = (heading < cfg.target_course) ? raw_err + FULL_CIRCLE_ERR : raw_err;
   assign err = (wrap_err > HALF_CIRCLE_ERR) ? wrap_err - FULL_CIRCLE_ERR : wrap_err;
   assign abs_err = err[10] ? -err : err;
   assign mag = abs_err[7:0];

   assign recip = RECIP_TABLE[mag];
   assign prod = PROD_W'(cfg.base_speed) * PROD_W'(recip);
   assign quot = prod[RECIP_SHIFT +: 8];
   assign slow_wide = $signed({2'b00, cfg.base_speed}) - $signed({1'b0, quot, 1'b0});
   assign slow = slow_wide[8:0];

   assign full_pos = $signed({1'b0, cfg.base_speed});
   assign full_neg = -full_pos;
   assign half_pos = $signed({2'b00, cfg.base_speed[7:1]});
   assign half_neg = -half_pos;

   always_comb begin
      result = '0;
      mode_next = mode;
      unique case (command)
         CMD_MOVE: mode_next.moving = 1'b1;
         CMD_TURN: mode_next.turning = 1'b1;
         CMD_STOP: mode_next = '0;
         CMD_TICK: begin
            if (cfg.enabled) begin
               if (!mode.moving && !mode.turning) begin
                  result.valid = 1'b1;
               end else begin
                  if (mode.turning) begin
                     if (err < -TURN_FULL_ERR) begin
                        result = '{1'b1, full_pos, full_neg};
                     end else if (err < -TURN_HALF_ERR) begin
                        result = '{1'b1, half_pos, half_neg};
                     end else if (err > TURN_FULL_ERR) begin
                        result = '{1'b1, full_neg, full_pos};
                     end else if (err > TURN_HALF_ERR) begin
                        result = '{1'b1, half_neg, half_pos};
                     end else begin
                        mode_next.turning = 1'b0;
                     end
                  end
                  if (!result.valid && mode.moving) begin
                     if (err < -MOVE_DEADBAND_ERR) begin
                        result = '{1'b1, full_pos, slow};
                     end else if (err > MOVE_DEADBAND_ERR) begin
                        result = '{1'b1, slow, full_pos};
                     end
                  end
               end
            end
         end
         default: mode_next = mode;
      endcase
   end

endmodule

/* rtl/heading_hold_autopilot.sv */
// Heading-hold controller for a differential-drive robot.
// The req channel takes one word per command: a tick carrying a compass
// heading, or a start-moving, start-turning or stop command. The rsp channel
// returns a left and right motor drive pair for each tick that issues drives.
// Ticks while disabled, mode commands and ticks that leave the drives as they
// are give no rsp word. The course, base speed and enable are set through the
// APB register port (enable at 0x0, course at 0x4, speed at 0x8); the user
// must set them only while idle; the block itself does not enforce this.
// A word is taken into an input register, the control law is evaluated
// combinationally and the drives are loaded into the output register that
// drives rsp_valid. One word is accepted every cycle while rsp is not stalled.
// When the receiver holds rsp_ready low, the output register keeps its word,
// the input register fills behind it and req_ready then drops until the
// output is taken. Reset empties both registers, clears the moving and
// turning modes and returns the registers to disabled, course 0, speed 127.
module heading_hold_autopilot (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_command,
   input  logic [8:0] req_heading,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [8:0] rsp_left_drive,
   output logic signed [8:0] rsp_right_drive,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [hhap_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hhap_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hhap_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import hhap_pkg::*;

   cfg_type cfg;
   logic in_valid_ff;
   logic in_valid_in;
   command_type command_ff;
   angle_type heading_ff;
   mode_type mode_ff;
   mode_type mode_next;
   result_type law_result;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   drive_type left_ff;
   drive_type right_ff;
   logic out_free;
   logic advance;

   hhap_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   hhap_law u_law (
      .command(command_ff),
      .heading(heading_ff),
      .cfg(cfg),
      .mode(mode_ff),
      .result(law_result),
      .mode_next(mode_next)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_free ? (advance && law_result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff <= mode_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         command_ff <= req_command;
         heading_ff <= req_heading;
      end
      if (advance && law_result.valid) begin
         left_ff <= law_result.left_drive;
         right_ff <= law_result.right_drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_drive = left_ff;
   assign rsp_right_drive = right_ff;

   a_held_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(command_ff) && $stable(heading_ff))
      else $error("Input register changed while the output was stalled.");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> left_ff != 9'h100 && right_ff != 9'h100)
      else $error("Drive value outside the motor range.");

   a_mode_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      advance && command_ff != CMD_TICK |=> !rsp_valid_ff)
      else $error("A mode command produced a drive word.");

   a_disabled_silent: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.enabled |=> !rsp_valid_ff && mode_ff == $past(mode_next))
      else $error("A disabled tick produced a drive word.");

endmodule
